@@ rtl/core/rcseq_pkg.sv @@
package rcseq_pkg;

   localparam int unsigned SEQ_W      = 31;
   localparam int unsigned LEN_W      = 16;
   localparam int unsigned WORD_W     = 32;
   localparam int unsigned REQ_DATA_W = 104;
   localparam int unsigned RSP_DATA_W = 104;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [LEN_W-1:0] SMALL_LIMIT_RESET = 16'd466;
   localparam logic [LEN_W-1:0] CAPACITY_RESET    = 16'd1400;
   localparam logic [SEQ_W-1:0] OUT_SEQ_RESET     = 31'd1;

   localparam logic ACTION_TRANSMIT = 1'b0;
   localparam logic ACTION_RECEIVE  = 1'b1;

   localparam logic CSR_SMALL_LIMIT = 1'b0;
   localparam logic CSR_CAPACITY    = 1'b1;

   typedef struct packed {
      logic              action;
      logic [LEN_W-1:0]  queued_length;
      logic              queued_overflowed;
      logic [LEN_W-1:0]  unreliable_length;
      logic [WORD_W-1:0] rx_word_one;
      logic [WORD_W-1:0] rx_word_two;
   } item_type;

   typedef struct packed {
      logic [WORD_W-1:0] tx_word_one;
      logic [WORD_W-1:0] tx_word_two;
      logic              reliable_included;
      logic              uncompressed_path;
      logic              unreliable_included;
      logic              packet_accepted;
      logic [SEQ_W-1:0]  dropped_count;
      logic              fatal;
   } result_type;

   typedef struct packed {
      logic [LEN_W-1:0] small_packet_limit;
      logic [LEN_W-1:0] message_capacity;
   } cfg_type;

endpackage

@@ rtl/core/rcseq_csr.sv @@
module rcseq_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rcseq_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [rcseq_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [rcseq_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                              csr_pready,
   output rcseq_pkg::cfg_type                cfg
);
   import rcseq_pkg::*;

   logic [LEN_W-1:0] small_limit_ff, small_limit_in;
   logic [LEN_W-1:0] capacity_ff, capacity_in;
   logic             write_en;
   logic             reg_sel;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      small_limit_in = small_limit_ff;
      capacity_in    = capacity_ff;
      if (write_en) begin
         unique case (reg_sel)
            CSR_SMALL_LIMIT: small_limit_in = csr_pwdata[LEN_W-1:0];
            CSR_CAPACITY:    capacity_in    = csr_pwdata[LEN_W-1:0];
            default:         small_limit_in = small_limit_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         small_limit_ff <= SMALL_LIMIT_RESET;
         capacity_ff    <= CAPACITY_RESET;
      end else begin
         small_limit_ff <= small_limit_in;
         capacity_ff    <= capacity_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         CSR_SMALL_LIMIT: csr_prdata = {{(CSR_DATA_W-LEN_W){1'b0}}, small_limit_ff};
         CSR_CAPACITY:    csr_prdata = {{(CSR_DATA_W-LEN_W){1'b0}}, capacity_ff};
         default:         csr_prdata = '0;
      endcase
   end

   assign cfg.small_packet_limit = small_limit_ff;
   assign cfg.message_capacity   = capacity_ff;

endmodule

@@ rtl/core/rcseq_engine.sv @@
module rcseq_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  rcseq_pkg::item_type    item,
   input  rcseq_pkg::cfg_type     cfg,
   output rcseq_pkg::result_type  result
);
   import rcseq_pkg::*;

   logic [SEQ_W-1:0] out_seq_ff, out_seq_in;
   logic [SEQ_W-1:0] in_seq_ff, in_seq_in;
   logic [SEQ_W-1:0] in_acked_seq_ff, in_acked_seq_in;
   logic             in_acked_rel_bit_ff, in_acked_rel_bit_in;
   logic [SEQ_W-1:0] last_rel_seq_ff, last_rel_seq_in;
   logic             rel_bit_ff, rel_bit_in;
   logic             in_rel_bit_ff, in_rel_bit_in;
   logic [LEN_W-1:0] rel_len_ff, rel_len_in;
   logic             fatal_ff, fatal_in;

   logic             resend;
   logic             new_msg;
   logic             snd_rel;
   logic [LEN_W-1:0] rel_part;
   logic [LEN_W:0]   total;
   logic             uncomp;
   logic [SEQ_W-1:0] rx_seq;
   logic [SEQ_W-1:0] rx_ack;
   logic             rx_rel_msg;
   logic             rx_rel_ack;
   logic             newer;

   assign rx_seq     = item.rx_word_one[SEQ_W-1:0];
   assign rx_rel_msg = item.rx_word_one[WORD_W-1];
   assign rx_ack     = item.rx_word_two[SEQ_W-1:0];
   assign rx_rel_ack = item.rx_word_two[WORD_W-1];
   assign newer      = rx_seq > in_seq_ff;

   assign resend   = (in_acked_seq_ff > last_rel_seq_ff) && (in_acked_rel_bit_ff != rel_bit_ff);
   assign new_msg  = (rel_len_ff == '0) && (item.queued_length != '0);
   assign snd_rel  = resend || new_msg;
   assign rel_part = !snd_rel ? '0 : (new_msg ? item.queued_length : rel_len_ff);
   assign total    = {1'b0, rel_part} + {1'b0, item.unreliable_length};
   assign uncomp   = total < {1'b0, cfg.small_packet_limit};

   always_comb begin
      out_seq_in          = out_seq_ff;
      in_seq_in           = in_seq_ff;
      in_acked_seq_in     = in_acked_seq_ff;
      in_acked_rel_bit_in = in_acked_rel_bit_ff;
      last_rel_seq_in     = last_rel_seq_ff;
      rel_bit_in          = rel_bit_ff;
      in_rel_bit_in       = in_rel_bit_ff;
      rel_len_in          = rel_len_ff;
      fatal_in            = fatal_ff;
      result              = '0;

      if (item.action == ACTION_TRANSMIT) begin
         if (item.queued_overflowed) begin
            fatal_in = 1'b1;
         end else begin
            if (new_msg) begin
               rel_len_in = item.queued_length;
               rel_bit_in = !rel_bit_ff;
            end
            if (snd_rel) begin
               last_rel_seq_in = out_seq_ff;
            end
            out_seq_in                 = out_seq_ff + 1'b1;
            result.tx_word_one         = {snd_rel, out_seq_ff};
            result.tx_word_two         = {in_rel_bit_ff, in_seq_ff};
            result.reliable_included   = snd_rel;
            result.uncompressed_path   = uncomp;
            result.unreliable_included = uncomp || (total <= {1'b0, cfg.message_capacity});
         end
      end else begin
         if (newer) begin
            result.packet_accepted = 1'b1;
            result.dropped_count   = rx_seq - in_seq_ff - 1'b1;
            if (rx_rel_ack == rel_bit_ff) begin
               rel_len_in = '0;
            end
            in_seq_in           = rx_seq;
            in_acked_seq_in     = rx_ack;
            in_acked_rel_bit_in = rx_rel_ack;
            in_rel_bit_in       = in_rel_bit_ff ^ rx_rel_msg;
         end
      end
      result.fatal = fatal_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_seq_ff          <= OUT_SEQ_RESET;
         in_seq_ff           <= '0;
         in_acked_seq_ff     <= '0;
         in_acked_rel_bit_ff <= 1'b0;
         last_rel_seq_ff     <= '0;
         rel_bit_ff          <= 1'b0;
         in_rel_bit_ff       <= 1'b0;
         rel_len_ff          <= '0;
         fatal_ff            <= 1'b0;
      end else if (advance) begin
         out_seq_ff          <= out_seq_in;
         in_seq_ff           <= in_seq_in;
         in_acked_seq_ff     <= in_acked_seq_in;
         in_acked_rel_bit_ff <= in_acked_rel_bit_in;
         last_rel_seq_ff     <= last_rel_seq_in;
         rel_bit_ff          <= rel_bit_in;
         in_rel_bit_ff       <= in_rel_bit_in;
         rel_len_ff          <= rel_len_in;
         fatal_ff            <= fatal_in;
      end
   end

endmodule

@@ rtl/core/reliable_channel_sequencer_unit.sv @@
// path: each input word is held in the input register, and its result word is registered in
// the output register and held there until it is taken with rsp_tready
// throughput: one word per cycle; input register, header logic and output register form
// a two-stage pipeline that stalls only when the output register is full and not taken
// reset: synchronous, active high; empties both stages, sets out sequence to 1, all other
// channel state and the fatal flag to 0, and the registers to 466 and 1400
module reliable_channel_sequencer_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // queued_length, queued_overflowed, unreliable_length, rx_word_one, rx_word_two
   input  logic [rcseq_pkg::REQ_DATA_W-1:0]  req_tdata,
   // action
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tx_word_one, tx_word_two, reliable_included, uncompressed_path, unreliable_included,
   // packet_accepted, dropped_count, fatal
   output logic [rcseq_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rcseq_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [rcseq_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [rcseq_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                              csr_pready
);
   import rcseq_pkg::*;

   cfg_type    cfg;
   item_type   item_ff, item_in;
   logic       item_valid_ff;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       out_free;
   logic       advance;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = item_valid_ff && out_free;
   assign req_tready = !item_valid_ff || advance;

   assign item_in.action            = req_tuser;
   assign item_in.queued_length     = req_tdata[15:0];
   assign item_in.queued_overflowed = req_tdata[16];
   assign item_in.unreliable_length = req_tdata[32:17];
   assign item_in.rx_word_one       = req_tdata[64:33];
   assign item_in.rx_word_two       = req_tdata[96:65];

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   rcseq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rcseq_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000,
                        rsp_ff.fatal,
                        rsp_ff.dropped_count,
                        rsp_ff.packet_accepted,
                        rsp_ff.unreliable_included,
                        rsp_ff.uncompressed_path,
                        rsp_ff.reliable_included,
                        rsp_ff.tx_word_two,
                        rsp_ff.tx_word_one};

endmodule
